>>> design/ftafc_pkg.sv
// Shared types and constants for the frame time averager and frame rate counter.
// Holds event codes, register indexes, the sequencer state type and divider status.
// No dependencies.
`default_nettype none

package ftafc_pkg;

  // Event kinds carried on the input channel's tuser.
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_PAUSE  = 2'd1;
  localparam logic [1:0] OP_RESUME = 2'd2;
  localparam logic [1:0] OP_RESET  = 2'd3;

  // Configuration register indexes (byte address divided by four).
  localparam logic [1:0] REG_TIMER_EN = 2'd0;
  localparam logic [1:0] REG_CPS      = 2'd1;
  localparam logic [1:0] REG_FALLBACK = 2'd2;

  localparam logic [31:0] CPS_RESET      = 32'd10000000;
  localparam logic [31:0] FALLBACK_RESET = 32'd166670;

  localparam int TIME_W = 63;
  localparam int ACC_W  = 33;

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_EXEC      = 13'b0000000000010,
    S_RESUME    = 13'b0000000000100,
    S_CLAMP     = 13'b0000000001000,
    S_SUM       = 13'b0000000010000,
    S_ADD       = 13'b0000000100000,
    S_DIV_START = 13'b0000001000000,
    S_DIV_WAIT  = 13'b0000010000000,
    S_RATE1     = 13'b0000100000000,
    S_RATE2     = 13'b0001000000000,
    S_TOT1      = 13'b0010000000000,
    S_TOT2      = 13'b0100000000000,
    S_OUT       = 13'b1000000000000
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

>>> design/ftafc_div.sv
// Restoring divider that produces one quotient bit per cycle.
// Uses ftafc_pkg for its status struct.
`default_nettype none

module ftafc_div
  import ftafc_pkg::*;
#(
  parameter int NUM_W = 38,
  parameter int DEN_W = 7
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [NUM_W-1:0] quo,
  output div_stat_t             stat
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] diff;

  always_comb begin
    shifted = {rem_r, quo_r[NUM_W-1]};
    diff    = {1'b0, shifted} - {2'b00, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // The remainder always stays below the divisor, so it fits DEN_W bits.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      if (!diff[DEN_W+1]) begin
        rem_r <= diff[DEN_W-1:0];
      end else begin
        rem_r <= shifted[DEN_W-1:0];
      end
      quo_r <= {quo_r[NUM_W-2:0], ~diff[DEN_W+1]};
    end
  end

  assign quo       = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

>>> design/frame_time_averager_fps_counter_top.sv
// Frame time averager with frame rate counter: top level, sequencer and state.
// Depends on ftafc_pkg and the serial divider ftafc_div.
//
//   channel | direction | payload
//   in_     | slave     | tdata: timestamp[62:0], pad; tuser: op[1:0]
//   out_    | master    | tdata: avg_delta, raw_delta, frame_rate, total_time, pad;
//           |           | tuser: is_paused
//   cfg_    | APB slave | timer_enabled @0x0, counts_per_second @0x4, fallback_delta @0x8
//
// A tick while running waits in DIV_WAIT on the bit-serial divider that forms the window average.
// Pause, reset and disabled-timer events go from EXEC straight to TOT1, TOT2 and OUT;
// a resume while paused passes through RESUME on the way.
// in_tready is high only while the sequencer is idle; a finished result waits in the
// output register, and the sequencer holds in its last step while that register is full.
// rst_n is synchronous; the delta history needs no clearing since entries are read only
// after the window has been filled.
`default_nettype none

module frame_time_averager_fps_counter_top
  import ftafc_pkg::*;
#(
  parameter int WINDOW      = 64,
  parameter int DELTA_WIDTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Input channel.
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [63:0]  in_tdata,   // [62:0] timestamp, [63] zero
  input  wire logic [1:0]   in_tuser,   // [1:0] op
  // Result channel.
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [143:0]      out_tdata,  // [31:0] avg_delta, [63:32] raw_delta,
                                        // [79:64] frame_rate, [142:80] total_time, [143] zero
  output logic              out_tuser,  // [0] is_paused
  // Configuration port.
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [3:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int DW     = DELTA_WIDTH;
  localparam int AW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW     = $clog2(WINDOW + 1);
  localparam int SW     = DW + CW;
  localparam int ASUM_W = ((DW > ACC_W) ? DW : ACC_W) + 1;
  localparam logic [DW-1:0] DELTA_MAX = {DW{1'b1}};

  // Configuration registers.
  logic        en_r;
  logic [31:0] cps_r;
  logic [31:0] fb_r;
  logic [1:0]  cfg_idx;

  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r  <= 1'b1;
      cps_r <= CPS_RESET;
      fb_r  <= FALLBACK_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_idx)
        REG_TIMER_EN: en_r  <= cfg_pwdata[0];
        REG_CPS:      cps_r <= cfg_pwdata;
        REG_FALLBACK: fb_r  <= cfg_pwdata;
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TIMER_EN: cfg_prdata = {31'd0, en_r};
      REG_CPS:      cfg_prdata = cps_r;
      REG_FALLBACK: cfg_prdata = fb_r;
      default:      cfg_prdata = '0;
    endcase
  end

  // Sequencer and timer state.
  state_t              state_r, state_nxt;
  logic [1:0]          op_r;
  logic [TIME_W-1:0]   ts_r;
  logic [TIME_W-1:0]   base_r, prev_r, cur_r, stop_r, ptot_r;
  logic                paused_r;
  logic [TIME_W-1:0]   work_r;
  logic [DW-1:0]       dl_r;
  logic [AW-1:0]       wpos_r;
  logic [CW-1:0]       samples_r;
  logic [SW-1:0]       sum_r;
  logic [31:0]         avg_r, raw_r;
  logic [15:0]         frames_r, rate_r;
  logic [ACC_W-1:0]    acc_r;
  logic                out_valid_r;
  logic [143:0]        out_data_r;
  logic                out_user_r;

  logic [DW-1:0]       hist_mem [WINDOW];
  logic [DW-1:0]       hist_rd_r;
  logic                full;
  logic [AW-1:0]       hist_waddr;
  logic [TIME_W-1:0]   dsel;
  logic [ASUM_W-1:0]   acc_sum;
  logic                out_load;
  logic                div_start;
  logic [SW-1:0]       div_quo;
  div_stat_t           div_stat;

  assign full       = (samples_r == CW'(WINDOW));
  assign hist_waddr = full ? wpos_r : samples_r[AW-1:0];
  assign dsel       = (work_r > TIME_W'(cps_r)) ? TIME_W'(fb_r) : work_r;
  assign acc_sum    = ASUM_W'(acc_r) + ASUM_W'(dl_r);
  assign out_load   = (state_r == S_OUT) && (!out_valid_r || out_tready);
  assign div_start  = (state_r == S_DIV_START);
  assign in_tready  = (state_r == S_IDLE);

  ftafc_div #(
    .NUM_W (SW),
    .DEN_W (CW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (sum_r),
    .den   (samples_r),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  // The history is read at the ring position every cycle; it is stable from the start of a tick until S_SUM uses it.
  always_ff @(posedge clk) begin
    hist_rd_r <= hist_mem[wpos_r];
    if (state_r == S_SUM) begin
      hist_mem[hist_waddr] <= dl_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:      if (in_tvalid) state_nxt = S_EXEC;
      S_EXEC: begin
        if (!en_r) begin
          state_nxt = S_TOT1;
        end else begin
          case (op_r)
            OP_TICK:   state_nxt = paused_r ? S_TOT1 : S_CLAMP;
            OP_RESUME: state_nxt = paused_r ? S_RESUME : S_TOT1;
            default:   state_nxt = S_TOT1;
          endcase
        end
      end
      S_RESUME:    state_nxt = S_TOT1;
      S_CLAMP:     state_nxt = S_SUM;
      S_SUM:       state_nxt = S_ADD;
      S_ADD:       state_nxt = S_DIV_START;
      S_DIV_START: state_nxt = S_DIV_WAIT;
      S_DIV_WAIT:  if (div_stat.done) state_nxt = S_RATE1;
      S_RATE1:     state_nxt = S_RATE2;
      S_RATE2:     state_nxt = S_TOT1;
      S_TOT1:      state_nxt = S_TOT2;
      S_TOT2:      state_nxt = S_OUT;
      S_OUT:       if (out_load) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      prev_r      <= '0;
      cur_r       <= '0;
      stop_r      <= '0;
      ptot_r      <= '0;
      paused_r    <= 1'b0;
      wpos_r      <= '0;
      samples_r   <= '0;
      sum_r       <= '0;
      avg_r       <= '0;
      raw_r       <= '0;
      frames_r    <= '0;
      acc_r       <= '0;
      rate_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_EXEC: begin
          if (en_r) begin
            case (op_r)
              OP_TICK: begin
                if (paused_r) begin
                  avg_r <= '0;
                  raw_r <= '0;
                end else begin
                  cur_r  <= ts_r;
                  prev_r <= ts_r;
                end
              end
              OP_PAUSE: begin
                if (!paused_r) begin
                  stop_r   <= ts_r;
                  paused_r <= 1'b1;
                  avg_r    <= '0;
                  raw_r    <= '0;
                end
              end
              OP_RESUME: begin
                if (paused_r) begin
                  prev_r   <= ts_r;
                  stop_r   <= '0;
                  paused_r <= 1'b0;
                end
              end
              default: begin
                base_r    <= ts_r;
                prev_r    <= ts_r;
                cur_r     <= ts_r;
                stop_r    <= '0;
                ptot_r    <= '0;
                paused_r  <= 1'b0;
                wpos_r    <= '0;
                samples_r <= '0;
                sum_r     <= '0;
                avg_r     <= '0;
                raw_r     <= '0;
                frames_r  <= '0;
                acc_r     <= '0;
                rate_r    <= '0;
              end
            endcase
          end
        end
        S_RESUME: ptot_r <= ptot_r + work_r;
        S_SUM: begin
          if (full) begin
            sum_r <= sum_r - SW'(hist_rd_r);
            if (wpos_r == AW'(WINDOW - 1)) begin
              wpos_r <= '0;
            end else begin
              wpos_r <= wpos_r + 1'b1;
            end
          end else begin
            samples_r <= samples_r + 1'b1;
          end
        end
        S_ADD:      sum_r <= sum_r + SW'(dl_r);
        S_CLAMP:    raw_r <= (|dsel[TIME_W-1:DW]) ? 32'(DELTA_MAX) : 32'(dsel[DW-1:0]);
        S_DIV_WAIT: if (div_stat.done) avg_r <= 32'(div_quo[DW-1:0]);
        S_RATE1: begin
          if (frames_r != 16'hFFFF) begin
            frames_r <= frames_r + 1'b1;
          end
          // The accumulator saturates at its full 33-bit range.
          if (|acc_sum[ASUM_W-1:ACC_W]) begin
            acc_r <= {ACC_W{1'b1}};
          end else begin
            acc_r <= acc_sum[ACC_W-1:0];
          end
        end
        S_RATE2: begin
          if (acc_r >= ACC_W'(cps_r)) begin
            rate_r   <= frames_r;
            frames_r <= '0;
            acc_r    <= acc_r - ACC_W'(cps_r);
          end
        end
        default: ;
      endcase
    end
  end

  // Payload and scratch registers.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r <= in_tuser;
      ts_r <= in_tdata[TIME_W-1:0];
    end
    case (state_r)
      S_EXEC:  work_r <= en_r && (op_r == OP_TICK) ? ts_r - prev_r : ts_r - stop_r;
      S_CLAMP: dl_r   <= (|dsel[TIME_W-1:DW]) ? DELTA_MAX : dsel[DW-1:0];
      S_TOT1:  work_r <= (paused_r ? stop_r : cur_r) - ptot_r;
      S_TOT2:  work_r <= en_r ? work_r - base_r : '0;
      default: ;
    endcase
    if (out_load) begin
      out_data_r <= {1'b0, work_r, rate_r, raw_r, avg_r};
      out_user_r <= paused_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for frame_time_averager_fps_counter_top: drives timer events on
// the input stream, checks each result against a behavioral copy of the timer or a typed row.
// Depends on ftafc_pkg and the design sources only.
`default_nettype none

module tb;
  import ftafc_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES  = 700;
  localparam logic [62:0] STAMP_MAX = {63{1'b1}};

  typedef struct packed {
    logic [31:0] avg;
    logic [31:0] raw;
    logic [15:0] rate;
    logic [62:0] total;
    logic        paused;
  } frame_stats_t;

  typedef struct packed {
    logic [1:0]   op;
    logic [62:0]  ts;
    logic         typed;
    frame_stats_t want;
  } opening_row_t;

  localparam frame_stats_t ALL_ZERO = '0;
  localparam frame_stats_t HELD_PAUSE = '{32'd0, 32'd0, 16'd0, 63'd200000, 1'b1};

  // Directed opening sequence under the reset register values. Rows with typed = 0 are
  // checked against the predictor only.
  localparam opening_row_t OPENING_EVENTS [0:15] = '{
    '{OP_TICK,   63'd0,        1'b1, ALL_ZERO},
    '{OP_TICK,   63'd166670,   1'b1, '{32'd83335, 32'd166670, 16'd0, 63'd166670, 1'b0}},
    '{OP_PAUSE,  63'd200000,   1'b1, HELD_PAUSE},
    '{OP_PAUSE,  63'd300000,   1'b1, HELD_PAUSE},
    '{OP_TICK,   63'd350000,   1'b1, HELD_PAUSE},
    '{OP_RESUME, 63'd500000,   1'b0, ALL_ZERO},
    '{OP_RESUME, 63'd600000,   1'b0, ALL_ZERO},
    '{OP_TICK,   63'd20500000, 1'b0, ALL_ZERO},
    '{OP_TICK,   63'd100,      1'b0, ALL_ZERO},
    '{OP_TICK,   STAMP_MAX,    1'b0, ALL_ZERO},
    '{OP_RESET,  63'h7FFF_FFFF_FFFF_FFF0, 1'b1, ALL_ZERO},
    '{OP_TICK,   63'd0,        1'b1, '{32'd16, 32'd16, 16'd0, 63'd16, 1'b0}},
    '{OP_TICK,   63'd10000000, 1'b1,
      '{32'd5000008, 32'd10000000, 16'd2, 63'd10000016, 1'b0}},
    '{OP_TICK,   63'd20000001, 1'b0, ALL_ZERO},
    '{OP_RESET,  63'd0,        1'b1, ALL_ZERO},
    '{OP_TICK,   STAMP_MAX,    1'b0, ALL_ZERO}
  };

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [63:0]   in_tdata = '0;    // [62:0] timestamp, [63] zero
  logic [1:0]    in_tuser = '0;    // [1:0] op
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [143:0]  out_tdata;        // [31:0] avg, [63:32] raw, [79:64] rate, [142:80] total
  logic          out_tuser;        // [0] is_paused
  logic          cfg_psel = 1'b0;
  logic          cfg_penable = 1'b0;
  logic          cfg_pwrite = 1'b0;
  logic [3:0]    cfg_paddr = '0;
  logic [31:0]   cfg_pwdata = '0;
  logic [31:0]   cfg_prdata;
  logic          cfg_pready;

  frame_time_averager_fps_counter_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #2 clk = ~clk;

  // Predicted timer state and register copies.
  logic        en_q;
  logic [31:0] cps_q;
  logic [31:0] fb_q;
  logic [62:0] base_t, prev_t, cur_t, stop_t, paused_sum;
  logic        paused_q;
  logic [31:0] hist [64];
  logic [5:0]  hist_pos;
  logic [6:0]  hist_cnt;
  logic [37:0] hist_sum;
  logic [31:0] avg_q, raw_q;
  logic [15:0] frame_cnt, rate_q;
  logic [32:0] sec_acc;

  frame_stats_t stats_due [$];

  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_served = 0;
  int unsigned settings_run = 0;
  int unsigned op_count [4] = '{0, 0, 0, 0};
  logic [62:0] stamp_now = '0;

  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  task automatic check_field(input string name, input logic [62:0] got, input logic [62:0] want);
    if (got !== want)
      note_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  task automatic restart_timer(input logic [62:0] ts);
    base_t = ts;
    prev_t = ts;
    cur_t = ts;
    stop_t = '0;
    paused_sum = '0;
    paused_q = 1'b0;
    foreach (hist[i]) hist[i] = '0;
    hist_pos = '0;
    hist_cnt = '0;
    hist_sum = '0;
    avg_q = '0;
    raw_q = '0;
    frame_cnt = '0;
    sec_acc = '0;
    rate_q = '0;
  endtask

  // Window averaging and frame counting for one tick while running.
  task automatic account_tick(input logic [62:0] ts);
    logic [63:0] d;
    logic [63:0] acc;
    cur_t = ts;
    d = {1'b0, 63'(cur_t - prev_t)};
    prev_t = cur_t;
    if (d > {32'd0, cps_q}) d = {32'd0, fb_q};
    if (d > 64'hFFFF_FFFF) d = 64'hFFFF_FFFF;
    raw_q = d[31:0];
    if (hist_cnt < 7'd64) begin
      hist[hist_cnt[5:0]] = d[31:0];
      hist_sum = hist_sum + d[31:0];
      hist_cnt = hist_cnt + 7'd1;
    end else begin
      hist_sum = hist_sum - hist[hist_pos] + d[31:0];
      hist[hist_pos] = d[31:0];
      hist_pos = hist_pos + 6'd1;
    end
    avg_q = 32'(hist_sum / hist_cnt);
    if (frame_cnt != 16'hFFFF) frame_cnt = frame_cnt + 16'd1;
    acc = {31'd0, sec_acc} + d;
    if (acc > 64'h1_FFFF_FFFF) acc = 64'h1_FFFF_FFFF;
    // At most one second leaves the accumulator per tick.
    if (acc >= {32'd0, cps_q}) begin
      rate_q = frame_cnt;
      frame_cnt = '0;
      acc = acc - cps_q;
    end
    sec_acc = acc[32:0];
  endtask

  task automatic predict_frame_stats(input logic [1:0] op, input logic [62:0] ts,
                                     output frame_stats_t r);
    logic [62:0] total;
    total = '0;
    if (en_q) begin
      case (op)
        OP_TICK: begin
          if (paused_q) begin
            avg_q = '0;
            raw_q = '0;
          end else begin
            account_tick(ts);
          end
        end
        OP_PAUSE: begin
          if (!paused_q) begin
            stop_t = ts;
            paused_q = 1'b1;
            avg_q = '0;
            raw_q = '0;
          end
        end
        OP_RESUME: begin
          if (paused_q) begin
            paused_sum = paused_sum + ts - stop_t;
            prev_t = ts;
            stop_t = '0;
            paused_q = 1'b0;
          end
        end
        default: restart_timer(ts);
      endcase
      total = (paused_q ? stop_t : cur_t) - paused_sum - base_t;
    end
    r = '{avg_q, raw_q, rate_q, total, paused_q};
  endtask

  // Next timestamp: mostly plausible frame intervals, with some one-second edges, long
  // stalls, backward steps and arbitrary counter values mixed in.
  function automatic logic [62:0] pick_stamp(input logic [62:0] now, input logic [31:0] sec);
    int unsigned k;
    logic [31:0] span;
    k = $urandom_range(99, 0);
    span = (sec >> 4) + 32'd1;
    if (k < 72) return now + 63'($urandom_range(span, 0));
    if (k < 82) return now + 63'(sec) + 63'($urandom_range(2, 0)) - 63'd1;
    if (k < 90) return now + 63'({$urandom, $urandom});
    if (k < 95) return now - 63'($urandom_range(span, 0));
    return 63'({$urandom, $urandom});
  endfunction

  task automatic offer_event(input logic [1:0] op, input logic [62:0] ts, input logic typed,
                             input frame_stats_t typed_want);
    frame_stats_t want;
    while ($urandom_range(99, 0) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {1'b0, ts};
    do @(posedge clk); while (!in_tready);
    predict_frame_stats(op, ts, want);
    stats_due.push_back(typed ? typed_want : want);
    op_count[op]++;
  endtask

  task automatic apb_write_check(input logic [1:0] idx, input logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    // Read the register back in the following transfer.
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== val)
      note_mismatch($sformatf("register %0d reads %0h, wrote %0h", idx, cfg_prdata, val));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results;
    in_tvalid <= 1'b0;
    while (stats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_timer(input logic en, input logic [31:0] cps, input logic [31:0] fb);
    drain_results();
    apb_write_check(REG_TIMER_EN, {31'd0, en});
    apb_write_check(REG_CPS, cps);
    apb_write_check(REG_FALLBACK, fb);
    en_q = en;
    cps_q = cps;
    fb_q = fb;
    settings_run++;
  endtask

  task automatic run_random_events(input int n, input int unsigned idle, input int unsigned stall);
    int unsigned r;
    logic [1:0] op;
    src_idle_pct = idle;
    sink_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(999, 0);
      op = (r < 840) ? OP_TICK : (r < 880) ? OP_PAUSE : (r < 995) ? OP_RESUME : OP_RESET;
      stamp_now = pick_stamp(stamp_now, cps_q);
      if (op == OP_RESET && $urandom_range(3, 0) == 0) stamp_now = 63'({$urandom, $urandom});
      offer_event(op, stamp_now, 1'b0, ALL_ZERO);
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles with %0d requests still due", cycles, stats_due.size());
      $display("frame_time_averager_fps_counter_top regression: fail");
      $finish;
    end
  end

  // Result side: random back-pressure, plus a long hold-off whenever one is asked for.
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (holds_served != holds_asked) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_served++;
      end else begin
        out_tready <= ($urandom_range(99, 0) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    frame_stats_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (stats_due.size() == 0) begin
        note_mismatch("result arrived with no request outstanding");
      end else begin
        want = stats_due.pop_front();
        check_field("avg_delta", 63'(out_tdata[31:0]), 63'(want.avg));
        check_field("raw_delta", 63'(out_tdata[63:32]), 63'(want.raw));
        check_field("frame_rate", 63'(out_tdata[79:64]), 63'(want.rate));
        check_field("total_time", out_tdata[142:80], want.total);
        check_field("is_paused", 63'(out_tuser), 63'(want.paused));
      end
    end
  end

  initial begin : stimulus
    en_q = 1'b1;
    cps_q = CPS_RESET;
    fb_q = FALLBACK_RESET;
    restart_timer('0);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (OPENING_EVENTS[i]) begin
      offer_event(OPENING_EVENTS[i].op, OPENING_EVENTS[i].ts, OPENING_EVENTS[i].typed,
                  OPENING_EVENTS[i].want);
      stamp_now = OPENING_EVENTS[i].ts;
    end

    program_timer(1'b1, CPS_RESET, FALLBACK_RESET);
    run_random_events(300, 0, 0);
    // A short second makes the rate latch often; a zero fallback shows clamped deltas as 0.
    program_timer(1'b1, 32'd1000, 32'd0);
    run_random_events(250, 78, 0);
    program_timer(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random_events(250, 0, 78);
    // Nearly every delta is clamped to a huge fallback, so the accumulator saturates.
    program_timer(1'b1, 32'd1, 32'hFFFF_FFFF);
    run_random_events(150, 6, 6);
    program_timer(1'b0, 32'd50000, 32'd1234);
    run_random_events(60, 6, 6);
    // With a zero second every tick taken while running latches the rate.
    program_timer(1'b1, 32'd0, 32'd5000);
    run_random_events(60, 0, 0);
    program_timer(1'b1, 32'd60000, 32'd1000);
    holds_asked++;
    run_random_events(250, 0, 0);
    drain_results();

    $display("Ran %0d events (%0d ticks, %0d pauses, %0d resumes, %0d resets) over %0d settings.",
             op_count[OP_TICK] + op_count[OP_PAUSE] + op_count[OP_RESUME] + op_count[OP_RESET],
             op_count[OP_TICK], op_count[OP_PAUSE], op_count[OP_RESUME], op_count[OP_RESET],
             settings_run);
    $display("Compared %0d results field by field, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("frame_time_averager_fps_counter_top regression: pass");
    end else begin
      $display("frame_time_averager_fps_counter_top regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
design/ftafc_pkg.sv
design/ftafc_div.sv
design/frame_time_averager_fps_counter_top.sv
dv/tb.sv
